// ===== src/skf_pkg.sv =====
// shared types, constants and helpers of the scalar kalman filter
`default_nettype none

package skf_pkg;

  // word formats
  localparam int DATA_W  = 32;
  localparam int FRAC_W  = 24;
  localparam int VAR_W   = DATA_W - 1;
  localparam int GAIN_W  = FRAC_W + 1;
  localparam int MAG_W   = DATA_W + 1;
  localparam int PROD_W  = MAG_W + VAR_W;
  localparam int CNT_W   = 5;
  localparam int IDX_W   = 3;

  // stream widths
  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 64;

  // register indexes
  localparam logic [IDX_W-1:0] REG_STEP_TIME     = 3'd0;
  localparam logic [IDX_W-1:0] REG_PROCESS_NOISE = 3'd1;
  localparam logic [IDX_W-1:0] REG_MEASURE_NOISE = 3'd2;
  localparam logic [IDX_W-1:0] REG_INIT_ANGLE    = 3'd3;
  localparam logic [IDX_W-1:0] REG_INIT_VARIANCE = 3'd4;

  // register reset values
  localparam logic [VAR_W-1:0]  RST_STEP_TIME     = 31'd167772;
  localparam logic [VAR_W-1:0]  RST_PROCESS_NOISE = 31'd1678;
  localparam logic [VAR_W-1:0]  RST_MEASURE_NOISE = 31'd167772;
  localparam logic [DATA_W-1:0] RST_INIT_ANGLE    = 32'd0;
  localparam logic [VAR_W-1:0]  RST_INIT_VARIANCE = 31'd16777216;

  // fixed-point constants
  localparam logic [GAIN_W-1:0] ONE_Q      = GAIN_W'(1) << FRAC_W;
  localparam logic [VAR_W-1:0]  VAR_MAX    = {VAR_W{1'b1}};
  localparam logic [DATA_W-1:0] S_MAX      = {1'b0, {VAR_W{1'b1}}};
  localparam logic [DATA_W-1:0] S_MIN      = {1'b1, {VAR_W{1'b0}}};
  localparam logic [CNT_W-1:0]  DIV_LAST   = CNT_W'(FRAC_W - 1);

  // controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_PRED_MUL,
    S_PRED_RND,
    S_PRED_ADD,
    S_DIV_INIT,
    S_DIV_FIRST,
    S_DIV_STEP,
    S_GAIN,
    S_CORR_MUL,
    S_CORR_RND,
    S_CORR_ADD,
    S_VAR_MUL,
    S_VAR_RND,
    S_DONE
  } state_t;

  // multiplier operand choice
  typedef enum logic [1:0] {
    MUL_DT,
    MUL_GAIN,
    MUL_VAR
  } mul_sel_t;

  // controller to datapath
  typedef struct packed {
    logic     load;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     rnd_en;
    logic     xp_add;
    logic     div_init;
    logic     div_first;
    logic     div_step;
    logic     gain_en;
    logic     x_add;
    logic     out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
  } status_t;

  // saturate a 33-bit signed sum to the signed word range
  function automatic logic [DATA_W-1:0] sat_s33(input logic [DATA_W:0] v);
    logic [DATA_W-1:0] r;
    r = v[DATA_W-1:0];
    if (v[DATA_W] != v[DATA_W-1]) begin
      r = v[DATA_W] ? S_MIN : S_MAX;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== src/skf_ctrl.sv =====
// sequencer for the predict, gain division and correct steps
`default_nettype none

module skf_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire skf_pkg::status_t stat,
  output skf_pkg::cmd_t         cmd
);

  skf_pkg::state_t             state, state_next;
  logic [skf_pkg::CNT_W-1:0]   cnt, cnt_next;

  // state and step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= skf_pkg::S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next  = state;
    cnt_next    = cnt;
    in_ready    = 1'b0;
    cmd         = '0;
    cmd.mul_sel = skf_pkg::MUL_DT;
    case (state)
      skf_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = skf_pkg::S_PRED_MUL;
        end
      end
      skf_pkg::S_PRED_MUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = skf_pkg::MUL_DT;
        state_next  = skf_pkg::S_PRED_RND;
      end
      skf_pkg::S_PRED_RND: begin
        cmd.rnd_en = 1'b1;
        state_next = skf_pkg::S_PRED_ADD;
      end
      skf_pkg::S_PRED_ADD: begin
        cmd.xp_add = 1'b1;
        state_next = skf_pkg::S_DIV_INIT;
      end
      skf_pkg::S_DIV_INIT: begin
        cmd.div_init = 1'b1;
        state_next   = skf_pkg::S_DIV_FIRST;
      end
      skf_pkg::S_DIV_FIRST: begin
        cmd.div_first = 1'b1;
        cnt_next      = '0;
        state_next    = skf_pkg::S_DIV_STEP;
      end
      skf_pkg::S_DIV_STEP: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + 1'b1;
        if (cnt == skf_pkg::DIV_LAST) begin
          state_next = skf_pkg::S_GAIN;
        end
      end
      skf_pkg::S_GAIN: begin
        cmd.gain_en = 1'b1;
        state_next  = skf_pkg::S_CORR_MUL;
      end
      skf_pkg::S_CORR_MUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = skf_pkg::MUL_GAIN;
        state_next  = skf_pkg::S_CORR_RND;
      end
      skf_pkg::S_CORR_RND: begin
        cmd.rnd_en = 1'b1;
        state_next = skf_pkg::S_CORR_ADD;
      end
      skf_pkg::S_CORR_ADD: begin
        cmd.x_add  = 1'b1;
        state_next = skf_pkg::S_VAR_MUL;
      end
      skf_pkg::S_VAR_MUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = skf_pkg::MUL_VAR;
        state_next  = skf_pkg::S_VAR_RND;
      end
      skf_pkg::S_VAR_RND: begin
        cmd.rnd_en = 1'b1;
        state_next = skf_pkg::S_DONE;
      end
      skf_pkg::S_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = skf_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = skf_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== src/skf_datapath.sv =====
// registers, shared multiplier, restoring divider and output register
`default_nettype none

module skf_datapath (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire skf_pkg::cmd_t                       cmd,
  output skf_pkg::status_t                         stat,
  input  wire logic                                cfg_we,
  input  wire logic [skf_pkg::IDX_W-1:0]           cfg_index,
  input  wire logic [skf_pkg::DATA_W-1:0]          cfg_data,
  input  wire logic [skf_pkg::IN_TDATA_W-1:0]      in_data,
  input  wire logic                                in_last,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [skf_pkg::OUT_TDATA_W-1:0]          out_data,
  output logic                                     out_last
);

  localparam int DW = skf_pkg::DATA_W;
  localparam int VW = skf_pkg::VAR_W;
  localparam int GW = skf_pkg::GAIN_W;
  localparam int MW = skf_pkg::MAG_W;
  localparam int PW = skf_pkg::PROD_W;
  localparam int FW = skf_pkg::FRAC_W;

  // configuration
  logic [VW-1:0] step_time, process_noise, measure_noise, init_variance;
  logic [DW-1:0] init_angle;

  // filter state
  logic [DW-1:0] estimate;
  logic [VW-1:0] estimate_variance;
  logic          run_active;

  // per-item working registers
  logic [DW-1:0] gyro, accel, x_cur, x_pred, x_new, term;
  logic [VW-1:0] p_pred;
  logic          last_r;
  logic [PW-1:0] prod;
  logic          prod_neg;
  logic [DW-1:0] den;
  logic [DW-1:0] rem;
  logic [GW-1:0] quot, gain;
  logic [DW:0]   innov;

  // output register
  logic [DW-1:0] out_angle;
  logic [VW-1:0] out_var;

  // combinational helpers
  logic [VW-1:0] p_start;
  logic [DW-1:0] p_sum;
  logic [MW-1:0] mul_a;
  logic [VW-1:0] mul_b;
  logic          mul_neg;
  logic [PW:0]   rnd_sum;
  logic [PW-FW:0] rnd_mag;
  logic [DW-1:0] term_sat;
  logic [DW:0]   rem_sh;
  logic [DW-1:0] gyro_mag;
  logic [DW:0]   innov_mag;

  assign p_start = run_active ? estimate_variance : init_variance;
  assign p_sum   = {1'b0, p_start} + {1'b0, process_noise};

  assign gyro_mag  = gyro[DW-1] ? (~gyro + 1'b1) : gyro;
  assign innov_mag = innov[DW] ? (~innov + 1'b1) : innov;

  // multiplier operand select
  always_comb begin
    case (cmd.mul_sel)
      skf_pkg::MUL_DT: begin
        mul_a   = {1'b0, gyro_mag};
        mul_b   = step_time;
        mul_neg = gyro[DW-1];
      end
      skf_pkg::MUL_GAIN: begin
        mul_a   = innov_mag;
        mul_b   = {{(VW-GW){1'b0}}, gain};
        mul_neg = innov[DW];
      end
      skf_pkg::MUL_VAR: begin
        mul_a   = {{(MW-GW){1'b0}}, skf_pkg::ONE_Q - gain};
        mul_b   = p_pred;
        mul_neg = 1'b0;
      end
      default: begin
        mul_a   = '0;
        mul_b   = '0;
        mul_neg = 1'b0;
      end
    endcase
  end

  // round magnitude half up, apply sign, saturate to the word range
  assign rnd_sum = {1'b0, prod} + ((PW + 1)'(1) << (FW - 1));
  assign rnd_mag = rnd_sum[PW:FW];

  always_comb begin
    if (prod_neg) begin
      if (rnd_mag > (PW - FW + 1)'(skf_pkg::S_MIN)) begin
        term_sat = skf_pkg::S_MIN;
      end else begin
        term_sat = ~rnd_mag[DW-1:0] + 1'b1;
      end
    end else begin
      if (rnd_mag > (PW - FW + 1)'(skf_pkg::S_MAX)) begin
        term_sat = skf_pkg::S_MAX;
      end else begin
        term_sat = rnd_mag[DW-1:0];
      end
    end
  end

  assign rem_sh = {rem, 1'b0};

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      step_time     <= skf_pkg::RST_STEP_TIME;
      process_noise <= skf_pkg::RST_PROCESS_NOISE;
      measure_noise <= skf_pkg::RST_MEASURE_NOISE;
      init_angle    <= skf_pkg::RST_INIT_ANGLE;
      init_variance <= skf_pkg::RST_INIT_VARIANCE;
    end else if (cfg_we) begin
      case (cfg_index)
        skf_pkg::REG_STEP_TIME:     step_time     <= cfg_data[VW-1:0];
        skf_pkg::REG_PROCESS_NOISE: process_noise <= cfg_data[VW-1:0];
        skf_pkg::REG_MEASURE_NOISE: measure_noise <= cfg_data[VW-1:0];
        skf_pkg::REG_INIT_ANGLE:    init_angle    <= cfg_data;
        skf_pkg::REG_INIT_VARIANCE: init_variance <= cfg_data[VW-1:0];
        default: ;
      endcase
    end
  end

  // input capture, shared multiplier, rounding, and the prediction and correction adds
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      gyro   <= in_data[DW-1:0];
      accel  <= in_data[2*DW-1:DW];
      last_r <= in_last;
      x_cur  <= run_active ? estimate : init_angle;
      p_pred <= p_sum[DW-1] ? skf_pkg::VAR_MAX : p_sum[VW-1:0];
    end
    if (cmd.mul_en) begin
      prod     <= mul_a * mul_b;
      prod_neg <= mul_neg;
    end
    if (cmd.rnd_en) begin
      term <= term_sat;
    end
    if (cmd.xp_add) begin
      x_pred <= skf_pkg::sat_s33({x_cur[DW-1], x_cur} + {term[DW-1], term});
    end
    if (cmd.x_add) begin
      x_new <= skf_pkg::sat_s33({x_pred[DW-1], x_pred} + {term[DW-1], term});
    end
  end

  // restoring divider for the gain, plus the gain and innovation registers
  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      den  <= {1'b0, p_pred} + {1'b0, measure_noise};
      rem  <= {1'b0, p_pred};
      quot <= '0;
    end else if (cmd.div_first) begin
      if (rem >= den) begin
        rem  <= rem - den;
        quot <= GW'(1);
      end
    end else if (cmd.div_step) begin
      if (rem_sh >= {1'b0, den}) begin
        rem  <= DW'(rem_sh - {1'b0, den});
        quot <= {quot[GW-2:0], 1'b1};
      end else begin
        rem  <= rem_sh[DW-1:0];
        quot <= {quot[GW-2:0], 1'b0};
      end
    end
    if (cmd.gain_en) begin
      gain  <= (den == '0) ? '0 : quot;
      innov <= {accel[DW-1], accel} - {x_pred[DW-1], x_pred};
    end
  end

  // filter state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      estimate          <= '0;
      estimate_variance <= '0;
      run_active        <= 1'b0;
      out_valid         <= 1'b0;
    end else if (cmd.out_load) begin
      estimate          <= x_new;
      estimate_variance <= term[VW-1:0];
      run_active        <= ~last_r;
      out_valid         <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_angle <= x_new;
      out_var   <= term[VW-1:0];
      out_last  <= last_r;
    end
  end

  assign out_data      = {{(skf_pkg::OUT_TDATA_W - DW - VW){1'b0}}, out_var, out_angle};
  assign stat.out_free = ~out_valid | out_ready;

endmodule

`default_nettype wire

// ===== src/scalar_kalman_filter_top.sv =====
// One-dimensional Kalman filter fusing a gyro rate and an accelerometer angle in signed
// Q8.24. Each input beat runs predict, gain and correct in order and yields one output beat;
// the block takes no new beat until the previous one has reached the output register. The gain
// comes from a restoring divider with a setup step and 25 quotient bits; the shared multiplier
// is used three times per sample, with a rounding step after each and a saturating add after
// the first two. A finished result waits in the output register while the next sample is
// taken. The first sample after reset or after a tlast beat starts from initial_angle and
// initial_variance. Configuration writes are taken at any edge with cfg_we high and must
// only happen while the filter is idle.
`default_nettype none

module scalar_kalman_filter_top (
  input  wire logic                               clk,
  input  wire logic                               rst,
  // configuration
  input  wire logic                               cfg_we,
  input  wire logic [skf_pkg::IDX_W-1:0]          cfg_index,
  input  wire logic [skf_pkg::DATA_W-1:0]         cfg_data,
  // sample stream
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  input  wire logic [skf_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // gyro_rate, accel_angle
  input  wire logic                               s_axis_tlast,  // last_sample
  // estimate stream
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  output logic [skf_pkg::OUT_TDATA_W-1:0]         m_axis_tdata,  // angle_estimate, variance
  output logic                                    m_axis_tlast   // run_end
);

  skf_pkg::cmd_t    cmd;
  skf_pkg::status_t stat;

  // sequencer
  skf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // arithmetic and storage
  skf_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (s_axis_tdata),
    .in_last   (s_axis_tlast),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .out_last  (m_axis_tlast)
  );

`ifndef SYNTHESIS
  // a sample beat starts a multi-cycle computation
  a_busy_after_beat: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input taken again right after a beat");

  // a result never overwrites one that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!m_axis_tvalid || m_axis_tready))
    else $error("output register overwritten");

  // after a result is posted the filter is ready again
  a_ready_after_result: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> (s_axis_tready && m_axis_tvalid))
    else $error("not idle after result");
`endif

endmodule

`default_nettype wire

// ===== test/tb.sv =====
// self-checking testbench for the scalar kalman filter with a built-in fixed-point predictor
`timescale 1ns / 100ps

module tb;

  // run bounds
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 50;
  localparam int REPORT_MAX = 10;

  // fixed-point bounds of the predictor
  localparam longint WORD_MAX = 64'sh0000_0000_7fff_ffff;
  localparam longint WORD_MIN = -64'sh0000_0000_8000_0000;
  localparam longint MAG_CAP = 64'sh4000_0000_0000_0000;
  localparam longint GAIN_ONE = 64'sd1 << skf_pkg::FRAC_W;

  // one output beat
  typedef struct packed {
    logic [skf_pkg::DATA_W-1:0] angle;
    logic [skf_pkg::VAR_W-1:0]  var_q;
    logic                       run_end;
  } estimate_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [skf_pkg::IDX_W-1:0] cfg_index;
  logic [skf_pkg::DATA_W-1:0] cfg_data;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [skf_pkg::IN_TDATA_W-1:0] s_axis_tdata;   // gyro_rate, accel_angle
  logic s_axis_tlast;                             // last_sample
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [skf_pkg::OUT_TDATA_W-1:0] m_axis_tdata;  // angle_estimate, variance
  logic m_axis_tlast;                             // run_end

  // predictor copy of registers and filter state
  longint cfg_step_time, cfg_proc_noise, cfg_meas_noise, cfg_angle0, cfg_var0;
  longint est_angle, est_var;
  bit run_open;

  estimate_t expected_estimates[$];
  int mismatches = 0;
  int cycle_count = 0;
  bit tx_gaps = 1'b0;
  bit rx_gaps = 1'b0;
  int rx_hold = 0;
  int rx_stall = 0;

  scalar_kalman_filter_top dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tlast(m_axis_tlast)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor

  function automatic longint clamp_angle(longint v);
    if (v > WORD_MAX) return WORD_MAX;
    if (v < WORD_MIN) return WORD_MIN;
    return v;
  endfunction

  function automatic longint clamp_var(longint v);
    if (v > WORD_MAX) return WORD_MAX;
    if (v < 0) return 0;
    return v;
  endfunction

  // exact product, magnitude rounded half up to FRAC_W fraction bits, capped
  function automatic longint round_product(longint unsigned a, longint unsigned b);
    logic [127:0] prod;
    prod = ({64'd0, a} * {64'd0, b} + (128'd1 << (skf_pkg::FRAC_W - 1))) >> skf_pkg::FRAC_W;
    if (prod > 128'h4000_0000_0000_0000) return MAG_CAP;
    return longint'(prod[63:0]);
  endfunction

  // signed times unsigned, magnitude rounded half up (ties away from zero), saturated to a word
  function automatic longint scale_signed(longint a, longint unsigned b);
    longint unsigned mag;
    if (a < 0) begin
      mag = -a;
      return clamp_angle(-round_product(mag, b));
    end
    return clamp_angle(round_product(a, b));
  endfunction

  // restoring division, integer bit plus FRAC_W fraction bits, truncated
  function automatic longint kalman_gain(longint unsigned num, longint unsigned den);
    longint unsigned q, r;
    q = 0;
    r = num;
    if (den == 0) return 0;
    if (r >= den) begin
      q = 1;
      r -= den;
    end
    for (int i = 0; i < skf_pkg::FRAC_W; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= den) begin
        r -= den;
        q |= 1;
      end
    end
    return longint'(q);
  endfunction

  function automatic void reset_filter_model();
    cfg_step_time  = skf_pkg::RST_STEP_TIME;
    cfg_proc_noise = skf_pkg::RST_PROCESS_NOISE;
    cfg_meas_noise = skf_pkg::RST_MEASURE_NOISE;
    cfg_angle0     = longint'($signed(skf_pkg::RST_INIT_ANGLE));
    cfg_var0       = skf_pkg::RST_INIT_VARIANCE;
    est_angle = 0;
    est_var   = 0;
    run_open  = 1'b0;
  endfunction

  // one predict/correct step, returns the beat it must produce
  function automatic estimate_t advance_filter(logic [skf_pkg::DATA_W-1:0] gyro,
                                               logic [skf_pkg::DATA_W-1:0] accel,
                                               logic last);
    longint u, z, x, p, x_pred, p_pred, s, k, innov;
    estimate_t r;
    u = longint'($signed(gyro));
    z = longint'($signed(accel));
    x = run_open ? est_angle : cfg_angle0;
    p = run_open ? est_var : cfg_var0;
    x_pred = clamp_angle(x + scale_signed(u, cfg_step_time));
    p_pred = clamp_var(p + cfg_proc_noise);
    s = p_pred + cfg_meas_noise;
    k = kalman_gain(p_pred, s);
    innov = z - x_pred;
    x = clamp_angle(x_pred + scale_signed(innov, k));
    p = clamp_var(round_product(GAIN_ONE - k, p_pred));
    est_angle = x;
    est_var   = p;
    run_open  = !last;
    r.angle   = x[skf_pkg::DATA_W-1:0];
    r.var_q   = p[skf_pkg::VAR_W-1:0];
    r.run_end = last;
    return r;
  endfunction

  // ---------------------------------------------------------------- drivers

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 96) return $urandom_range(1, 4);
    return $urandom_range(12, 50);
  endfunction

  task automatic cfg_write(logic [skf_pkg::IDX_W-1:0] idx, logic [skf_pkg::DATA_W-1:0] data);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      skf_pkg::REG_STEP_TIME:     cfg_step_time  = data[skf_pkg::VAR_W-1:0];
      skf_pkg::REG_PROCESS_NOISE: cfg_proc_noise = data[skf_pkg::VAR_W-1:0];
      skf_pkg::REG_MEASURE_NOISE: cfg_meas_noise = data[skf_pkg::VAR_W-1:0];
      skf_pkg::REG_INIT_ANGLE:    cfg_angle0     = longint'($signed(data));
      skf_pkg::REG_INIT_VARIANCE: cfg_var0       = data[skf_pkg::VAR_W-1:0];
      default: ;
    endcase
  endtask

  // offer one sample beat and book its estimate once taken
  task automatic send_sample(logic [skf_pkg::DATA_W-1:0] gyro,
                             logic [skf_pkg::DATA_W-1:0] accel, logic last);
    int gap;
    gap = tx_gaps ? pick_gap() : 0;
    if (gap > 0) begin
      @(negedge clk);
      s_axis_tvalid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_axis_tvalid = 1'b1;
    s_axis_tdata = {accel, gyro};
    s_axis_tlast = last;
    do @(posedge clk); while (!s_axis_tready);
    expected_estimates.insert(expected_estimates.size(), advance_filter(gyro, accel, last));
  endtask

  // stop offering and wait for every booked estimate
  task automatic wait_drained();
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    while (expected_estimates.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // receiver: optional long hold-off, else random stalls when rx_gaps is set, else always ready
  always @(negedge clk) begin
    if (rx_hold > 0) begin
      rx_hold--;
      m_axis_tready = 1'b0;
    end else if (rx_stall > 0) begin
      rx_stall--;
      m_axis_tready = 1'b0;
    end else if (rx_gaps) begin
      rx_stall = pick_gap();
      m_axis_tready = (rx_stall == 0);
      if (rx_stall > 0) rx_stall--;
    end else begin
      m_axis_tready = 1'b1;
    end
  end

  // ---------------------------------------------------------------- checker

  task automatic note_mismatch(string what, logic [63:0] want, logic [63:0] got);
    mismatches++;
    if (mismatches <= REPORT_MAX)
      $display("mismatch %s: expected %h got %h", what, want, got);
  endtask

  always @(posedge clk) begin : beat_check
    estimate_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      if (expected_estimates.size() == 0) begin
        note_mismatch("unexpected beat", '0, {m_axis_tlast, m_axis_tdata[62:0]});
      end else begin
        want = expected_estimates.pop_front();
        if (m_axis_tdata[skf_pkg::DATA_W-1:0] !== want.angle)
          note_mismatch("angle_estimate", want.angle, m_axis_tdata[skf_pkg::DATA_W-1:0]);
        if (m_axis_tdata[skf_pkg::DATA_W+skf_pkg::VAR_W-1:skf_pkg::DATA_W] !== want.var_q)
          note_mismatch("variance", want.var_q,
                        m_axis_tdata[skf_pkg::DATA_W+skf_pkg::VAR_W-1:skf_pkg::DATA_W]);
        if (m_axis_tlast !== want.run_end)
          note_mismatch("run_end", want.run_end, m_axis_tlast);
      end
    end
  end

  // ---------------------------------------------------------------- stimulus helpers

  function automatic logic [skf_pkg::DATA_W-1:0] pick_var_reg();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return {1'b0, skf_pkg::VAR_MAX};
      2: return $urandom();
      default: return $urandom_range(0, 1 << 24);
    endcase
  endfunction

  function automatic logic [skf_pkg::DATA_W-1:0] pick_angle_reg();
    case ($urandom_range(0, 9))
      0: return skf_pkg::S_MIN;
      1: return skf_pkg::S_MAX;
      2: return $urandom();
      default: return $urandom_range(0, 1 << 27) - (1 << 26);
    endcase
  endfunction

  // ---------------------------------------------------------------- tests

  // reset register values, field extremes, runs of four, one and two beats
  task automatic test_reset_defaults();
    send_sample('0, '0, 1'b0);
    send_sample(skf_pkg::S_MAX, skf_pkg::S_MAX, 1'b0);
    send_sample(skf_pkg::S_MIN, skf_pkg::S_MIN, 1'b0);
    send_sample(skf_pkg::S_MAX, skf_pkg::S_MIN, 1'b1);
    send_sample(skf_pkg::S_MIN, skf_pkg::S_MAX, 1'b1);
    send_sample(32'h0100_0000, 32'h0080_0000, 1'b0);
    send_sample(32'hff00_0000, 32'hff80_0000, 1'b1);
    wait_drained();
  endtask

  // largest step, noise and variance registers and the lowest initial angle drive sums and products into saturation
  task automatic test_saturation_extremes();
    cfg_write(skf_pkg::REG_STEP_TIME, {1'b0, skf_pkg::VAR_MAX});
    cfg_write(skf_pkg::REG_PROCESS_NOISE, {1'b0, skf_pkg::VAR_MAX});
    cfg_write(skf_pkg::REG_MEASURE_NOISE, {1'b0, skf_pkg::VAR_MAX});
    cfg_write(skf_pkg::REG_INIT_ANGLE, skf_pkg::S_MIN);
    cfg_write(skf_pkg::REG_INIT_VARIANCE, {1'b0, skf_pkg::VAR_MAX});
    send_sample(skf_pkg::S_MAX, skf_pkg::S_MAX, 1'b0);
    send_sample(skf_pkg::S_MIN, skf_pkg::S_MIN, 1'b0);
    send_sample(skf_pkg::S_MAX, skf_pkg::S_MIN, 1'b1);
    send_sample(skf_pkg::S_MIN, skf_pkg::S_MAX, 1'b1);
    wait_drained();
  endtask

  // zero variance and zero noise give a zero gain denominator
  task automatic test_zero_denominator();
    cfg_write(skf_pkg::REG_STEP_TIME, '0);
    cfg_write(skf_pkg::REG_PROCESS_NOISE, '0);
    cfg_write(skf_pkg::REG_MEASURE_NOISE, '0);
    cfg_write(skf_pkg::REG_INIT_ANGLE, skf_pkg::S_MAX);
    cfg_write(skf_pkg::REG_INIT_VARIANCE, '0);
    send_sample(32'h1234_5678, 32'h8765_4321, 1'b0);
    send_sample(skf_pkg::S_MAX, skf_pkg::S_MIN, 1'b1);
    send_sample(skf_pkg::S_MIN, 32'h0, 1'b1);
    wait_drained();
  endtask

  // writes past the last register change nothing; top data bit is masked
  task automatic test_unused_index();
    cfg_write(skf_pkg::REG_STEP_TIME, 32'h8002_8f5c);
    cfg_write(skf_pkg::REG_MEASURE_NOISE, 32'h8002_8f5c);
    cfg_write(skf_pkg::REG_INIT_VARIANCE, 32'h8100_0000);
    for (int i = skf_pkg::REG_INIT_VARIANCE + 1; i < (1 << skf_pkg::IDX_W); i++)
      cfg_write(skf_pkg::IDX_W'(i), $urandom());
    send_sample(32'h0200_0000, 32'h0100_0000, 1'b0);
    send_sample(32'hfe00_0000, 32'h0000_0000, 1'b1);
    wait_drained();
  endtask

  // receiver holds off while beats keep coming, then the sender waits it out
  task automatic test_backpressure();
    cfg_write(skf_pkg::REG_STEP_TIME, skf_pkg::RST_STEP_TIME);
    cfg_write(skf_pkg::REG_PROCESS_NOISE, skf_pkg::RST_PROCESS_NOISE);
    cfg_write(skf_pkg::REG_MEASURE_NOISE, skf_pkg::RST_MEASURE_NOISE);
    cfg_write(skf_pkg::REG_INIT_ANGLE, skf_pkg::RST_INIT_ANGLE);
    cfg_write(skf_pkg::REG_INIT_VARIANCE, skf_pkg::RST_INIT_VARIANCE);
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    @(posedge clk);
    rx_hold = 400;
    for (int i = 0; i < 12; i++)
      send_sample($urandom_range(0, 1 << 26) - (1 << 25),
                  $urandom_range(0, 1 << 24), i == 11);
    wait_drained();
    for (int i = 0; i < 12; i++)
      send_sample($urandom(), $urandom(), $urandom_range(0, 3) == 0);
    wait_drained();
  endtask

  // random registers, then runs of random length with plausible or raw samples
  task automatic test_random_phase(int beats, bit gaps);
    logic [skf_pkg::DATA_W-1:0] base, gyro, accel;
    int len, sent;
    cfg_write(skf_pkg::REG_STEP_TIME, pick_var_reg());
    cfg_write(skf_pkg::REG_PROCESS_NOISE, pick_var_reg());
    cfg_write(skf_pkg::REG_MEASURE_NOISE, pick_var_reg());
    cfg_write(skf_pkg::REG_INIT_ANGLE, pick_angle_reg());
    cfg_write(skf_pkg::REG_INIT_VARIANCE, pick_var_reg());
    tx_gaps = gaps;
    rx_gaps = gaps;
    sent = 0;
    while (sent < beats) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 16);
      base = $urandom_range(0, 1 << 27) - (1 << 26);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 9) == 0) begin
          gyro = $urandom();
          accel = $urandom();
        end else begin
          gyro = $urandom_range(0, 1 << 26) - (1 << 25);
          accel = base + $urandom_range(0, 1 << 22) - (1 << 21);
        end
        send_sample(gyro, accel, i == len - 1);
      end
      sent += len;
    end
    wait_drained();
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tlast = 1'b0;
    m_axis_tready = 1'b0;
    reset_filter_model();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    repeat (4) @(posedge clk);

    test_reset_defaults();
    test_saturation_extremes();
    test_zero_denominator();
    test_unused_index();
    test_backpressure();
    for (int phase = 0; phase < 6; phase++)
      test_random_phase(120, phase != 2);

    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/skf_pkg.sv
src/skf_ctrl.sv
src/skf_datapath.sv
src/scalar_kalman_filter_top.sv
test/tb.sv
